// ===== src/rrss_pkg.sv =====
// rrss_pkg: shared types for the rounded-rectangle strip generator
// holds the sequencer phase enum; no dependencies
`default_nettype none

package rrss_pkg;

  // sequencer phases: setup, first walk region, region change, second walk region, emission
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM,
    ST_SPAN_X,
    ST_SPAN_Y,
    ST_CLAMP_SPAN,
    ST_CLAMP_MAX,
    ST_SQ_W,
    ST_SQ_H,
    ST_ASQ_H,
    ST_INIT_YD,
    ST_INIT_D,
    ST_INIT_B3,
    ST_INIT_P1,
    ST_INIT_P1A,
    ST_INIT_SAB,
    ST_WALK1,
    ST_TR_DIFF,
    ST_TR_MUL3,
    ST_TR_HALF1,
    ST_TR_SUBX,
    ST_TR_SUBY,
    ST_TR_HALF2,
    ST_TR_ADD,
    ST_TR_Q0,
    ST_TR_Q0A,
    ST_TR_Q1,
    ST_TR_Q1A,
    ST_WALK2,
    ST_EMIT_IN,
    ST_EMIT_UP,
    ST_EMIT_LO
  } phase_t;

endpackage

`default_nettype wire

// ===== src/round_rect_scanline_strips_core.sv =====
// round_rect_scanline_strips_core: strips of a rounded rectangle via a midpoint ellipse walk
// uses rrss_pkg (phase enum) and rrss_ram (edge pair buffer)
// run time grows with the steps of the two walk regions and the buffered row pairs;
// a zero corner skips the walk and gives its single strip, marked last
// throughput: one item at a time, busy stays high until the last strip has been issued
// results are pushed one per cycle with out_strobe and cannot be stalled; reset clears the sequencer
`default_nettype none

module round_rect_scanline_strips_core #(
  parameter int MAX_CORNER_HEIGHT = 60,
  parameter int MAX_CORNER_WIDTH  = 1024,
  parameter int PAIR_DEPTH        = 32,
  parameter int COORD_BITS        = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  signed [COORD_BITS-1:0] in_box_left,
  input  wire  signed [COORD_BITS-1:0] in_box_top,
  input  wire  signed [COORD_BITS-1:0] in_box_right,
  input  wire  signed [COORD_BITS-1:0] in_box_bottom,
  input  wire  signed [COORD_BITS-1:0] in_corner_width,
  input  wire  signed [COORD_BITS-1:0] in_corner_height,
  output logic                         out_strobe,
  output logic signed [COORD_BITS-1:0] out_strip_top,
  output logic signed [COORD_BITS-1:0] out_strip_bottom,
  output logic signed [COORD_BITS-1:0] out_strip_left,
  output logic signed [COORD_BITS-1:0] out_strip_right,
  output logic                         out_last_strip
);

  import rrss_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int CW_W   = $clog2(MAX_CORNER_WIDTH + 1);
  localparam int CH_W   = $clog2(MAX_CORNER_HEIGHT + 1);
  localparam int ASQ_W  = 2 * CW_W - 2;
  localparam int BSQ_W  = 2 * CH_W - 2;
  localparam int MA_W   = (ASQ_W > CH_W) ? ASQ_W : CH_W;
  localparam int MB_W   = (CW_W > CH_W) ? CW_W : CH_W;
  localparam int PR_W   = MA_W + MB_W;
  localparam int ACC_A  = ASQ_W + 2 * CH_W + 4;
  localparam int ACC_W  = (ACC_A > C + 2) ? ACC_A : C + 2;
  localparam int AW     = $clog2(PAIR_DEPTH);
  localparam int NP_W   = $clog2(PAIR_DEPTH + 1);
  localparam int ROW_W  = C + 2;

  phase_t state_r, state_nxt;

  // item registers
  logic signed [C-1:0] l_r, t_r, r_r, b_r;
  logic [C:0]          w_r, h_r;
  logic                zero_r;
  logic [C:0]          span_x_r, span_y_r;
  logic [CW_W-1:0]     cw_r;
  logic [CH_W-1:0]     ch_r;
  logic [PR_W-1:0]     prod_r;
  logic [ASQ_W-1:0]    asq_r;
  logic [BSQ_W-1:0]    bsq_r;

  // walk registers
  logic signed [ACC_W-1:0] d_r, xd_r, yd_r, aux0_r, aux1_r, sab_r, tmp_r;
  logic [C-1:0]            el_r, er_r;
  logic signed [ROW_W-1:0] top_r, bot_r;
  logic [NP_W-1:0]         np_r, k_r;
  logic [C-1:0]            up_row_r, lo_row_r;

  // output registers
  logic         out_strobe_r, out_last_r;
  logic [C-1:0] out_top_r, out_bot_r, out_left_r, out_right_r;

  // shared multiplier
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [PR_W-1:0] mul_p;

  // shared adder
  logic signed [ACC_W-1:0] alu_a, alu_b, alu_sum, alu_half;
  logic                    alu_sub;

  logic signed [ACC_W-1:0] asq_x, bsq_x, asq2_x, bsq2_x;
  logic                    d_pos, d_neg, walk1_go, walk2_go, pair_room;
  logic [ASQ_W-1:0]        sq_a;
  logic [BSQ_W-1:0]        sq_b;
  logic [NP_W-1:0]         k_inc;

  // emission and buffer control
  logic         emit, e_last;
  logic [C-1:0] e_top, e_bot, e_left, e_right;
  logic         ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [2*C-1:0] ram_q;

  // edge pair buffer
  rrss_ram #(
    .WIDTH (2 * C),
    .DEPTH (PAIR_DEPTH)
  ) u_pairs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (np_r[AW-1:0]),
    .wdata ({er_r, el_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // widened constants and status
  assign asq_x     = ACC_W'(asq_r);
  assign bsq_x     = ACC_W'(bsq_r);
  assign asq2_x    = asq_x <<< 1;
  assign bsq2_x    = bsq_x <<< 1;
  assign d_neg     = d_r[ACC_W-1];
  assign d_pos     = !d_r[ACC_W-1] && (d_r != '0);
  assign walk1_go  = xd_r < yd_r;
  assign walk2_go  = !yd_r[ACC_W-1];
  assign pair_room = np_r < NP_W'(PAIR_DEPTH);
  assign sq_a      = prod_r[ASQ_W+1:2];
  assign sq_b      = prod_r[BSQ_W+1:2];
  assign k_inc     = k_r + NP_W'(1);
  assign busy      = state_r != ST_IDLE;

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_SQ_W: begin
        mul_a = MA_W'(cw_r);
        mul_b = MB_W'(cw_r);
      end
      ST_SQ_H: begin
        mul_a = MA_W'(ch_r);
        mul_b = MB_W'(ch_r);
      end
      default: begin
        mul_a = MA_W'(asq_r);
        mul_b = MB_W'(ch_r);
      end
    endcase
  end

  assign mul_p = PR_W'(mul_a) * PR_W'(mul_b);

  // adder operand select
  always_comb begin
    alu_a   = d_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_SPAN_X: begin
        alu_a   = ACC_W'(r_r);
        alu_b   = ACC_W'(l_r);
        alu_sub = 1'b1;
      end
      ST_SPAN_Y: begin
        alu_a   = ACC_W'(b_r);
        alu_b   = ACC_W'(t_r);
        alu_sub = 1'b1;
      end
      ST_INIT_YD: begin
        alu_b = bsq_x;
      end
      ST_INIT_D: begin
        alu_b   = yd_r >>> 1;
        alu_sub = 1'b1;
      end
      ST_INIT_B3: begin
        alu_a = bsq2_x;
        alu_b = bsq_x;
      end
      ST_INIT_P1: begin
        alu_a   = aux0_r;
        alu_b   = yd_r;
        alu_sub = 1'b1;
      end
      ST_INIT_P1A: begin
        alu_a = aux1_r;
        alu_b = asq2_x;
      end
      ST_INIT_SAB: begin
        alu_a = asq2_x;
        alu_b = bsq2_x;
      end
      ST_WALK1: begin
        alu_b = d_pos ? aux1_r : aux0_r;
      end
      ST_TR_DIFF: begin
        alu_a   = asq_x;
        alu_b   = bsq_x;
        alu_sub = 1'b1;
      end
      ST_TR_MUL3: begin
        alu_a = tmp_r <<< 1;
        alu_b = tmp_r;
      end
      ST_TR_HALF1, ST_TR_HALF2: begin
        alu_a = tmp_r;
        alu_b = ACC_W'(tmp_r[ACC_W-1]);
      end
      ST_TR_SUBX: begin
        alu_a   = tmp_r;
        alu_b   = xd_r;
        alu_sub = 1'b1;
      end
      ST_TR_SUBY: begin
        alu_a   = tmp_r;
        alu_b   = yd_r;
        alu_sub = 1'b1;
      end
      ST_TR_ADD: begin
        alu_b = tmp_r;
      end
      ST_TR_Q0: begin
        alu_a   = asq2_x;
        alu_b   = yd_r;
        alu_sub = 1'b1;
      end
      ST_TR_Q0A: begin
        alu_a = aux0_r;
        alu_b = asq_x;
      end
      ST_TR_Q1: begin
        alu_a = aux0_r;
        alu_b = xd_r;
      end
      ST_TR_Q1A: begin
        alu_a = aux1_r;
        alu_b = bsq2_x;
      end
      ST_WALK2: begin
        alu_b = d_neg ? aux1_r : aux0_r;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + ACC_W'(alu_sub);
  assign alu_half = alu_sum >>> 1;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, strip emission and buffer control
  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    e_top     = t_r;
    e_bot     = b_r;
    e_left    = l_r;
    e_right   = r_r;
    e_last    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = k_inc[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM:       state_nxt = ST_SPAN_X;
      ST_SPAN_X: begin
        if (zero_r) begin
          emit      = 1'b1;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SPAN_Y;
        end
      end
      ST_SPAN_Y:     state_nxt = ST_CLAMP_SPAN;
      ST_CLAMP_SPAN: state_nxt = ST_CLAMP_MAX;
      ST_CLAMP_MAX:  state_nxt = ST_SQ_W;
      ST_SQ_W:       state_nxt = ST_SQ_H;
      ST_SQ_H:       state_nxt = ST_ASQ_H;
      ST_ASQ_H:      state_nxt = ST_INIT_YD;
      ST_INIT_YD:    state_nxt = ST_INIT_D;
      ST_INIT_D:     state_nxt = ST_INIT_B3;
      ST_INIT_B3:    state_nxt = ST_INIT_P1;
      ST_INIT_P1:    state_nxt = ST_INIT_P1A;
      ST_INIT_P1A:   state_nxt = ST_INIT_SAB;
      ST_INIT_SAB:   state_nxt = ST_WALK1;
      ST_WALK1: begin
        if (walk1_go) begin
          ram_we = d_pos && pair_room;
        end else begin
          state_nxt = ST_TR_DIFF;
        end
      end
      ST_TR_DIFF:    state_nxt = ST_TR_MUL3;
      ST_TR_MUL3:    state_nxt = ST_TR_HALF1;
      ST_TR_HALF1:   state_nxt = ST_TR_SUBX;
      ST_TR_SUBX:    state_nxt = ST_TR_SUBY;
      ST_TR_SUBY:    state_nxt = ST_TR_HALF2;
      ST_TR_HALF2:   state_nxt = ST_TR_ADD;
      ST_TR_ADD:     state_nxt = ST_TR_Q0;
      ST_TR_Q0:      state_nxt = ST_TR_Q0A;
      ST_TR_Q0A:     state_nxt = ST_TR_Q1;
      ST_TR_Q1:      state_nxt = ST_TR_Q1A;
      ST_TR_Q1A:     state_nxt = ST_WALK2;
      ST_WALK2: begin
        if (walk2_go) begin
          ram_we = pair_room;
        end else begin
          state_nxt = ST_EMIT_IN;
        end
      end
      ST_EMIT_IN: begin
        // inner strip uses the final edges; prefetch the first pair
        ram_re    = 1'b1;
        ram_raddr = '0;
        emit      = top_r <= bot_r;
        e_top     = top_r[C-1:0];
        e_bot     = bot_r[C-1:0];
        e_left    = el_r;
        e_right   = er_r;
        e_last    = np_r == '0;
        state_nxt = (np_r == '0) ? ST_IDLE : ST_EMIT_UP;
      end
      ST_EMIT_UP: begin
        emit      = 1'b1;
        e_top     = up_row_r;
        e_bot     = up_row_r + C'(1);
        e_left    = ram_q[C-1:0];
        e_right   = ram_q[2*C-1:C];
        state_nxt = ST_EMIT_LO;
      end
      ST_EMIT_LO: begin
        emit    = 1'b1;
        e_top   = lo_row_r;
        e_bot   = lo_row_r + C'(1);
        e_left  = ram_q[C-1:0];
        e_right = ram_q[2*C-1:C];
        e_last  = k_inc == np_r;
        if (k_inc == np_r) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_EMIT_UP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          l_r <= in_box_left;
          t_r <= in_box_top;
          r_r <= in_box_right;
          b_r <= in_box_bottom;
          w_r <= (C+1)'(in_corner_width);
          h_r <= (C+1)'(in_corner_height);
        end
      end
      ST_NORM: begin
        // normalize the box, take corner magnitudes
        if (l_r > r_r) begin
          l_r <= r_r;
          r_r <= l_r;
        end
        if (t_r > b_r) begin
          t_r <= b_r;
          b_r <= t_r;
        end
        zero_r <= (w_r == '0) || (h_r == '0);
        w_r    <= w_r[C] ? -w_r : w_r;
        h_r    <= h_r[C] ? -h_r : h_r;
      end
      ST_SPAN_X: span_x_r <= alu_sum[C:0];
      ST_SPAN_Y: span_y_r <= alu_sum[C:0];
      ST_CLAMP_SPAN: begin
        if (span_x_r < w_r) begin
          w_r <= span_x_r;
        end
        if (span_y_r < h_r) begin
          h_r <= span_y_r;
        end
      end
      ST_CLAMP_MAX: begin
        cw_r <= (w_r > (C+1)'(MAX_CORNER_WIDTH)) ? CW_W'(MAX_CORNER_WIDTH) : w_r[CW_W-1:0];
        ch_r <= (h_r > (C+1)'(MAX_CORNER_HEIGHT)) ? CH_W'(MAX_CORNER_HEIGHT) : h_r[CH_W-1:0];
      end
      ST_SQ_W: prod_r <= mul_p;
      ST_SQ_H: begin
        asq_r  <= (sq_a == '0) ? ASQ_W'(1) : sq_a;
        prod_r <= mul_p;
      end
      ST_ASQ_H: begin
        bsq_r  <= (sq_b == '0) ? BSQ_W'(1) : sq_b;
        prod_r <= mul_p;
        d_r    <= ACC_W'(asq_r >> 2);
      end
      ST_INIT_YD: begin
        yd_r  <= ACC_W'(prod_r);
        d_r   <= alu_sum;
        xd_r  <= '0;
        el_r  <= l_r + C'(cw_r >> 1);
        er_r  <= r_r - C'(cw_r >> 1);
        top_r <= ROW_W'(t_r);
        bot_r <= ROW_W'(b_r);
        np_r  <= '0;
      end
      ST_INIT_D:   d_r    <= alu_sum;
      ST_INIT_B3:  aux0_r <= alu_sum;
      ST_INIT_P1:  aux1_r <= alu_sum;
      ST_INIT_P1A: aux1_r <= alu_sum;
      ST_INIT_SAB: sab_r  <= alu_sum;
      ST_WALK1: begin
        // region one: one column per step, row pair when the term turns positive
        if (walk1_go) begin
          d_r    <= alu_sum;
          xd_r   <= xd_r + bsq2_x;
          aux0_r <= aux0_r + bsq2_x;
          el_r   <= el_r - C'(1);
          er_r   <= er_r + C'(1);
          if (d_pos) begin
            yd_r   <= yd_r - asq2_x;
            aux1_r <= aux1_r + sab_r;
            top_r  <= top_r + ROW_W'(1);
            bot_r  <= bot_r - ROW_W'(1);
            if (pair_room) begin
              np_r <= np_r + NP_W'(1);
            end
          end else begin
            aux1_r <= aux1_r + bsq2_x;
          end
        end
      end
      ST_TR_DIFF, ST_TR_MUL3, ST_TR_SUBX, ST_TR_SUBY: tmp_r <= alu_sum;
      ST_TR_HALF1, ST_TR_HALF2:                       tmp_r <= alu_half;
      ST_TR_ADD:                                      d_r   <= alu_sum;
      ST_TR_Q0, ST_TR_Q0A:                            aux0_r <= alu_sum;
      ST_TR_Q1, ST_TR_Q1A:                            aux1_r <= alu_sum;
      ST_WALK2: begin
        // region two: one row pair per step, column moves when the term is negative
        if (walk2_go) begin
          d_r    <= alu_sum;
          yd_r   <= yd_r - asq2_x;
          aux0_r <= aux0_r + asq2_x;
          top_r  <= top_r + ROW_W'(1);
          bot_r  <= bot_r - ROW_W'(1);
          if (pair_room) begin
            np_r <= np_r + NP_W'(1);
          end
          if (d_neg) begin
            el_r   <= el_r - C'(1);
            er_r   <= er_r + C'(1);
            aux1_r <= aux1_r + sab_r;
          end else begin
            aux1_r <= aux1_r + asq2_x;
          end
        end
      end
      ST_EMIT_IN: begin
        up_row_r <= t_r;
        lo_row_r <= b_r - C'(1);
        k_r      <= '0;
      end
      ST_EMIT_UP: up_row_r <= up_row_r + C'(1);
      ST_EMIT_LO: begin
        lo_row_r <= lo_row_r - C'(1);
        k_r      <= k_inc;
      end
      default: begin
        d_r <= d_r;
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_top_r   <= e_top;
      out_bot_r   <= e_bot;
      out_left_r  <= e_left;
      out_right_r <= e_right;
      out_last_r  <= e_last;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_strip_top    = out_top_r;
  assign out_strip_bottom = out_bot_r;
  assign out_strip_left   = out_left_r;
  assign out_strip_right  = out_right_r;
  assign out_last_strip   = out_last_r;

endmodule

`default_nettype wire

// ===== src/rrss_ram.sv =====
// rrss_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rrss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire              clk,
  input  wire              we,
  input  wire  [AW-1:0]    waddr,
  input  wire  [WIDTH-1:0] wdata,
  input  wire              re,
  input  wire  [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/rrss_strip_checker.sv =====
// rrss_strip_checker: watches the rectangle and strip ports of the strip generator,
// predicts the strips of each accepted rectangle and compares them in order
// standalone, no package needed; parameters must match the block under test
module rrss_strip_checker #(
  parameter int MAX_CORNER_HEIGHT = 60,
  parameter int MAX_CORNER_WIDTH  = 1024,
  parameter int PAIR_DEPTH        = 32,
  parameter int COORD_BITS        = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire  signed [COORD_BITS-1:0] in_box_left,
  input  wire  signed [COORD_BITS-1:0] in_box_top,
  input  wire  signed [COORD_BITS-1:0] in_box_right,
  input  wire  signed [COORD_BITS-1:0] in_box_bottom,
  input  wire  signed [COORD_BITS-1:0] in_corner_width,
  input  wire  signed [COORD_BITS-1:0] in_corner_height,
  input  wire                          out_strobe,
  input  wire  signed [COORD_BITS-1:0] out_strip_top,
  input  wire  signed [COORD_BITS-1:0] out_strip_bottom,
  input  wire  signed [COORD_BITS-1:0] out_strip_left,
  input  wire  signed [COORD_BITS-1:0] out_strip_right,
  input  wire                          out_last_strip,
  output int                           fail_count,
  output int                           pending,
  output int                           strips_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] bottom;
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] right;
    logic                         last;
  } strip_t;

  strip_t strips_due[$];
  int     mismatches;
  int     seen;

  function automatic strip_t make_strip(input longint t, input longint b,
                                        input longint l, input longint r);
    strip_t s;
    s.top    = t[COORD_BITS-1:0];
    s.bottom = b[COORD_BITS-1:0];
    s.left   = l[COORD_BITS-1:0];
    s.right  = r[COORD_BITS-1:0];
    s.last   = 1'b0;
    return s;
  endfunction

  // strips of one rounded rectangle, appended in emission order
  function automatic void predict_strips(
    input logic signed [COORD_BITS-1:0] bl, input logic signed [COORD_BITS-1:0] bt,
    input logic signed [COORD_BITS-1:0] br, input logic signed [COORD_BITS-1:0] bb,
    input logic signed [COORD_BITS-1:0] cw, input logic signed [COORD_BITS-1:0] ch);
    longint l, t, r, b, w, h, swap;
    longint asq, bsq, d, xd, yd, el, er, row_up, row_lo;
    logic signed [COORD_BITS-1:0] pair_l [PAIR_DEPTH];
    logic signed [COORD_BITS-1:0] pair_r [PAIR_DEPTH];
    strip_t s;
    strip_t burst[$];
    int np;
    l = bl; t = bt; r = br; b = bb; w = cw; h = ch;
    np = 0;

    // normalize inverted edges
    if (l > r) begin
      swap = l; l = r; r = swap;
    end
    if (t > b) begin
      swap = t; t = b; b = swap;
    end

    // zero corner as given: the plain rectangle
    if (w == 0 || h == 0) begin
      s = make_strip(t, b, l, r);
      s.last = 1'b1;
      strips_due.push_back(s);
      return;
    end

    // absolute corner size, clamped to the box, then to the maxima
    if (w < 0) w = -w;
    if (h < 0) h = -h;
    if (w > r - l) w = r - l;
    if (h > b - t) h = b - t;
    if (w > MAX_CORNER_WIDTH) w = MAX_CORNER_WIDTH;
    if (h > MAX_CORNER_HEIGHT) h = MAX_CORNER_HEIGHT;

    asq = w * w / 4;
    bsq = h * h / 4;
    if (asq == 0) asq = 1;
    if (bsq == 0) bsq = 1;
    d = bsq - asq * h / 2 + asq / 4;
    xd = 0;
    yd = asq * h;
    el = l + w / 2;
    er = r - w / 2;
    row_up = t;
    row_lo = b;

    // first region: x steps every iteration, y only when the term goes positive
    while (xd < yd) begin
      if (d > 0) begin
        if (np < PAIR_DEPTH) begin
          pair_l[np] = el[COORD_BITS-1:0];
          pair_r[np] = er[COORD_BITS-1:0];
          np++;
        end
        row_up++;
        row_lo--;
        yd -= 2 * asq;
        d -= yd;
      end
      el--;
      er++;
      xd += 2 * bsq;
      d += bsq + xd;
    end

    // second region: y steps every iteration
    d += (3 * (asq - bsq) / 2 - (xd + yd)) / 2;
    while (yd >= 0) begin
      if (np < PAIR_DEPTH) begin
        pair_l[np] = el[COORD_BITS-1:0];
        pair_r[np] = er[COORD_BITS-1:0];
        np++;
      end
      row_up++;
      row_lo--;
      if (d < 0) begin
        el--;
        er++;
        xd += 2 * bsq;
        d += xd;
      end
      yd -= 2 * asq;
      d += asq - yd;
    end

    // inner strip first, then upper and mirrored lower row per pair
    if (row_up <= row_lo)
      burst.push_back(make_strip(row_up, row_lo, el, er));
    for (int k = 0; k < np; k++) begin
      burst.push_back(make_strip(t + k, t + k + 1, pair_l[k], pair_r[k]));
      burst.push_back(make_strip(b - 1 - k, b - k, pair_l[k], pair_r[k]));
    end
    if (burst.size() > 0) begin
      s = burst.pop_back();
      s.last = 1'b1;
      burst.push_back(s);
    end
    foreach (burst[i])
      strips_due.push_back(burst[i]);
  endfunction

  function automatic void flag_strip(input string what, input strip_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected t=%0d b=%0d l=%0d r=%0d last=%0b, got t=%0d b=%0d l=%0d r=%0d last=%0b",
               what, want.top, want.bottom, want.left, want.right, want.last,
               out_strip_top, out_strip_bottom, out_strip_left, out_strip_right,
               out_last_strip);
  endfunction

  // compare strips before queueing a new rectangle, the strobe belongs to older work
  always @(posedge clk) begin
    strip_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        seen++;
        if (strips_due.size() == 0) begin
          want = '0;
          flag_strip("strip with none outstanding", want);
        end else begin
          want = strips_due.pop_front();
          if (want.top !== out_strip_top || want.bottom !== out_strip_bottom ||
              want.left !== out_strip_left || want.right !== out_strip_right ||
              want.last !== out_last_strip)
            flag_strip("strip mismatch", want);
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        predict_strips(in_box_left, in_box_top, in_box_right, in_box_bottom,
                       in_corner_width, in_corner_height);
    end
    fail_count  <= mismatches;
    pending     <= strips_due.size();
    strips_seen <= seen;
  end

endmodule

// ===== tb/round_rect_scanline_strips_core_tb.sv =====
// round_rect_scanline_strips_core_tb: drives rectangles into the strip generator
// and gives the verdict; relies on rrss_strip_checker and the core RTL
module round_rect_scanline_strips_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CORNER_HEIGHT = 60;
  localparam int MAX_CORNER_WIDTH  = 1024;
  localparam int PAIR_DEPTH        = 32;
  localparam int COORD_BITS        = 16;
  localparam int RANDOM_BOXES      = 370;
  localparam int CYCLE_LIMIT       = 1500000;
  localparam int TAIL_CYCLES       = 100;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
    logic signed [COORD_BITS-1:0] corner_width;
    logic signed [COORD_BITS-1:0] corner_height;
  } box_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  wire                          busy;
  logic signed [COORD_BITS-1:0] in_box_left;
  logic signed [COORD_BITS-1:0] in_box_top;
  logic signed [COORD_BITS-1:0] in_box_right;
  logic signed [COORD_BITS-1:0] in_box_bottom;
  logic signed [COORD_BITS-1:0] in_corner_width;
  logic signed [COORD_BITS-1:0] in_corner_height;
  wire                          out_strobe;
  wire  signed [COORD_BITS-1:0] out_strip_top;
  wire  signed [COORD_BITS-1:0] out_strip_bottom;
  wire  signed [COORD_BITS-1:0] out_strip_left;
  wire  signed [COORD_BITS-1:0] out_strip_right;
  wire                          out_last_strip;

  int fail_count;
  int pending;
  int strips_seen;
  int cycles;
  int boxes_sent;
  int zero_corner_boxes;
  int directed_boxes;

  round_rect_scanline_strips_core #(
    .MAX_CORNER_HEIGHT(MAX_CORNER_HEIGHT),
    .MAX_CORNER_WIDTH (MAX_CORNER_WIDTH),
    .PAIR_DEPTH       (PAIR_DEPTH),
    .COORD_BITS       (COORD_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_box_left     (in_box_left),
    .in_box_top      (in_box_top),
    .in_box_right    (in_box_right),
    .in_box_bottom   (in_box_bottom),
    .in_corner_width (in_corner_width),
    .in_corner_height(in_corner_height),
    .out_strobe      (out_strobe),
    .out_strip_top   (out_strip_top),
    .out_strip_bottom(out_strip_bottom),
    .out_strip_left  (out_strip_left),
    .out_strip_right (out_strip_right),
    .out_last_strip  (out_last_strip)
  );

  rrss_strip_checker #(
    .MAX_CORNER_HEIGHT(MAX_CORNER_HEIGHT),
    .MAX_CORNER_WIDTH (MAX_CORNER_WIDTH),
    .PAIR_DEPTH       (PAIR_DEPTH),
    .COORD_BITS       (COORD_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_box_left     (in_box_left),
    .in_box_top      (in_box_top),
    .in_box_right    (in_box_right),
    .in_box_bottom   (in_box_bottom),
    .in_corner_width (in_corner_width),
    .in_corner_height(in_corner_height),
    .out_strobe      (out_strobe),
    .out_strip_top   (out_strip_top),
    .out_strip_bottom(out_strip_bottom),
    .out_strip_left  (out_strip_left),
    .out_strip_right (out_strip_right),
    .out_last_strip  (out_last_strip),
    .fail_count      (fail_count),
    .pending         (pending),
    .strips_seen     (strips_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d strips outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic box_t mk_box(input int l, input int t, input int r, input int b,
                                  input int w, input int h);
    box_t bx;
    bx.left = l; bx.top = t; bx.right = r; bx.bottom = b;
    bx.corner_width = w; bx.corner_height = h;
    return bx;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic box_t random_box();
    box_t bx;
    logic signed [COORD_BITS-1:0] x0, y0, swap;
    int kind;
    kind = $urandom_range(0, 99);
    x0 = $urandom;
    y0 = $urandom;
    if (kind < 55) begin
      // ordinary rounded box of modest size
      bx.left = x0; bx.right = x0 + $urandom_range(0, 400);
      bx.top = y0; bx.bottom = y0 + $urandom_range(0, 150);
      bx.corner_width = $urandom_range(1, 200);
      bx.corner_height = $urandom_range(1, 80);
    end else if (kind < 65) begin
      // wide box with corners near or past the maxima, or the most negative size
      bx.left = x0; bx.right = x0 + $urandom_range(1000, 3000);
      bx.top = y0; bx.bottom = y0 + $urandom_range(50, 300);
      bx.corner_width = $urandom_range(0, 1) ? $urandom_range(900, 32767) : 16'sh8000;
      bx.corner_height = $urandom_range(0, 1) ? $urandom_range(50, 32767) : 16'sh8000;
    end else if (kind < 75) begin
      // zero corner on either axis
      bx.left = x0; bx.right = x0 + $urandom_range(0, 500);
      bx.top = y0; bx.bottom = y0 + $urandom_range(0, 500);
      bx.corner_width = $urandom_range(0, 1) ? 0 : $urandom;
      bx.corner_height = (bx.corner_width == 0 && $urandom_range(0, 1)) ? $urandom : 0;
    end else if (kind < 85) begin
      // degenerate or tiny box
      bx.left = x0; bx.right = x0 + $urandom_range(0, 3);
      bx.top = y0; bx.bottom = y0 + $urandom_range(0, 3);
      bx.corner_width = $urandom_range(0, 16) - 8;
      bx.corner_height = $urandom_range(0, 16) - 8;
    end else begin
      // raw fields
      bx.left = $urandom; bx.right = $urandom; bx.top = $urandom; bx.bottom = $urandom;
      bx.corner_width = $urandom; bx.corner_height = $urandom;
      return bx;
    end
    if ($urandom_range(0, 3) == 0) bx.corner_width = -bx.corner_width;
    if ($urandom_range(0, 3) == 0) bx.corner_height = -bx.corner_height;
    if ($urandom_range(0, 3) == 0) begin
      swap = bx.left; bx.left = bx.right; bx.right = swap;
    end
    if ($urandom_range(0, 3) == 0) begin
      swap = bx.top; bx.top = bx.bottom; bx.bottom = swap;
    end
    return bx;
  endfunction

  // present one item, hold it until accepted, then, if a gap is given, idle with noise on the fields
  task automatic send_box(input box_t bx, input int gap);
    start            <= 1'b1;
    in_box_left      <= bx.left;
    in_box_top       <= bx.top;
    in_box_right     <= bx.right;
    in_box_bottom    <= bx.bottom;
    in_corner_width  <= bx.corner_width;
    in_corner_height <= bx.corner_height;
    do @(posedge clk); while (busy);
    boxes_sent++;
    if (bx.corner_width == 0 || bx.corner_height == 0) zero_corner_boxes++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_box_left      <= $urandom;
        in_box_top       <= $urandom;
        in_box_right     <= $urandom;
        in_box_bottom    <= $urandom;
        in_corner_width  <= $urandom;
        in_corner_height <= $urandom;
        @(posedge clk);
      end
    end
  endtask

  // hold off until every predicted strip has arrived
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // stimulus
  initial begin
    box_t directed[$];
    int   gap;
    int   burst_left;
    burst_left = 0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_box_left      <= '0;
    in_box_top       <= '0;
    in_box_right     <= '0;
    in_box_bottom    <= '0;
    in_corner_width  <= '0;
    in_corner_height <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero corners, inversion, clamping, degenerate boxes, field extremes
    directed.push_back(mk_box(10, 20, 110, 120, 0, 30));
    directed.push_back(mk_box(10, 20, 110, 120, 30, 0));
    directed.push_back(mk_box(200, 150, -50, -60, 0, 0));
    directed.push_back(mk_box(0, 0, 100, 80, 20, 16));
    directed.push_back(mk_box(300, -40, -100, -300, -50, -24));
    directed.push_back(mk_box(-5000, -2000, 5000, 2000, -32768, -32768));
    directed.push_back(mk_box(7, 7, 7, 7, 5, 5));
    directed.push_back(mk_box(40, 0, 40, 50, 10, 10));
    directed.push_back(mk_box(0, 100, 64, 101, 16, 16));
    directed.push_back(mk_box(-32768, -32768, 32767, 32767, 32767, 32767));
    directed.push_back(mk_box(0, 0, 50, 50, 1, 1));
    directed.push_back(mk_box(0, 0, 50, 50, 2, 2));
    directed.push_back(mk_box(-100, -100, 2000, 200, 1024, 60));
    directed.push_back(mk_box(0, 0, 300, 300, 1, 60));
    directed.push_back(mk_box(0, 0, 3000, 300, 1024, 1));
    directed.push_back(mk_box(32600, 32700, 32767, 32767, 60, 60));
    directed.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(mk_box(500, 0, 100, 90, -1, -1));
    directed.push_back(mk_box(0, 0, 2000, 61, 2000, 61));
    directed.push_back(mk_box(0, 0, 3, 3, 32767, -32768));
    foreach (directed[i])
      send_box(directed[i], pick_gap());
    directed_boxes = directed.size();
    wait_drained();

    // random part with back-to-back bursts and occasional full drains
    for (int i = 0; i < RANDOM_BOXES; i++) begin
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 25);
      end
      send_box(random_box(), gap);
      if ($urandom_range(0, 49) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d rectangles (%0d directed, %0d with a zero corner)",
             boxes_sent, directed_boxes, zero_corner_boxes);
    $display("%0d strips compared, %0d failures", strips_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
